// ===== hw/rtl/mcid_pkg.sv =====
// mcid_pkg: shared types, codes and the record length function of the
// mesh corner index dedup block. No dependencies.
package mcid_pkg;

  localparam int POS_W   = 13;
  localparam int REF_W   = 16;
  localparam int INDEX_W = 16;
  localparam int WORDS_W = 7;
  localparam int CFG_W   = 16;

  // operation codes
  localparam logic OP_RESTART = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INDEX_OFFSET = 2'd0;
  localparam logic [1:0] CFG_ATTR_MODE    = 2'd1;
  localparam logic [1:0] CFG_STRIDE       = 2'd2;

  // attribute modes and attribute words per mode
  localparam logic [1:0] MODE_POS_NRM = 2'd0;
  localparam logic [1:0] MODE_POS_TEX = 2'd1;
  localparam logic [3:0] WORDS_POS_NRM     = 4'd6;
  localparam logic [3:0] WORDS_POS_TEX     = 4'd5;
  localparam logic [3:0] WORDS_POS_NRM_TEX = 4'd8;

  typedef enum logic [1:0] {
    KIND_LOOKUP,
    KIND_RESTART,
    KIND_RANGE
  } kind_t;

  // classified request, references already zero-based
  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   pos;
    logic [REF_W-1:0]   tex;
    logic [REF_W-1:0]   nrm;
  } item_t;

  typedef struct packed {
    logic [REF_W-1:0]   normal;
    logic [REF_W-1:0]   texcoord;
    logic [INDEX_W-1:0] index;
  } pair_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_offset;
    logic [1:0]         attribute_mode;
    logic [7:0]         stride_bytes;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] assigned_index;
    logic               is_new;
    logic [11:0]        fetch_position;
    logic [REF_W-1:0]   fetch_normal;
    logic [REF_W-1:0]   fetch_texcoord;
    logic [WORDS_W-1:0] record_words;
    logic [1:0]         status;
  } res_t;

  // attribute words plus padding words up to the stride
  function automatic logic [WORDS_W-1:0] record_len(logic [1:0] mode, logic [7:0] stride);
    logic [3:0] w;
    logic [7:0] w4;
    logic [7:0] pad;
    logic [7:0] sum;
    unique case (mode)
      MODE_POS_NRM: w = WORDS_POS_NRM;
      MODE_POS_TEX: w = WORDS_POS_TEX;
      default:      w = WORDS_POS_NRM_TEX;
    endcase
    w4  = {2'b00, w, 2'b00};
    pad = (stride > w4) ? ((stride - w4) >> 2) : 8'd0;
    sum = {4'd0, w} + pad;
    return sum[WORDS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/mesh_corner_index_dedup.sv =====
// mesh_corner_index_dedup: top level, configuration registers and the
// front / queue / back chain. Depends on mcid_pkg, mcid_front, mcid_queue, mcid_back.
//
//   channel   ports                                   direction  handshake
//   in        in_operation in_position_ref            input      in_valid / in_ready
//             in_texcoord_ref in_normal_ref
//   out       out_assigned_index out_is_new           output     out_valid / out_ready
//             out_fetch_* out_record_words out_status
//   cfg       cfg_index cfg_wdata                     input      cfg_we, no wait
//
// a lookup goes through the back end in order: registered read of the count and
// pair row memories, a registered match over the row, then the decision and
// the read-modify-write of the row; out-of-range and restart requests load their
// result straight from the idle state; after reset, and after every restart
// request, a sweep over all POSITION_SLOTS addresses clears the count memory;
// requests queue up in front meanwhile. The front register and the two-entry queue
// keep accepting requests while a result waits in the output register
module mesh_corner_index_dedup import mcid_pkg::*; #(
  parameter int POSITION_SLOTS     = 4096,
  parameter int PAIRS_PER_POSITION = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [POS_W-1:0]   in_position_ref,
  input  logic [REF_W-1:0]   in_texcoord_ref,
  input  logic [REF_W-1:0]   in_normal_ref,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_assigned_index,
  output logic               out_is_new,
  output logic [11:0]        out_fetch_position,
  output logic [REF_W-1:0]   out_fetch_normal,
  output logic [REF_W-1:0]   out_fetch_texcoord,
  output logic [WORDS_W-1:0] out_record_words,
  output logic [1:0]         out_status,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  cfg_t  cfg_r;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  res_t  res;

  // configuration registers, offset only takes effect at the next restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.index_offset   <= '0;
      cfg_r.attribute_mode <= 2'd2;
      cfg_r.stride_bytes   <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INDEX_OFFSET: cfg_r.index_offset   <= cfg_wdata;
        CFG_ATTR_MODE:    cfg_r.attribute_mode <= cfg_wdata[1:0];
        CFG_STRIDE:       cfg_r.stride_bytes   <= cfg_wdata[7:0];
        default: ;  // index beyond the register list is ignored
      endcase
    end
  end

  // front: zero-based references and request classification
  mcid_front #(
    .POSITION_SLOTS(POSITION_SLOTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_position_ref(in_position_ref),
    .in_texcoord_ref(in_texcoord_ref),
    .in_normal_ref  (in_normal_ref),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // short queue decouples the front from the back
  mcid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item)
  );

  // back: pair lists, index counter and result register
  mcid_back #(
    .POSITION_SLOTS    (POSITION_SLOTS),
    .PAIRS_PER_POSITION(PAIRS_PER_POSITION)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_assigned_index = res.assigned_index;
  assign out_is_new         = res.is_new;
  assign out_fetch_position = res.fetch_position;
  assign out_fetch_normal   = res.fetch_normal;
  assign out_fetch_texcoord = res.fetch_texcoord;
  assign out_record_words   = res.record_words;
  assign out_status         = res.status;

endmodule

// ===== hw/rtl/mcid_front.sv =====
// mcid_front: input stage, makes references zero-based and classifies
// each request. Depends on mcid_pkg.
module mcid_front import mcid_pkg::*; #(
  parameter int POSITION_SLOTS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [POS_W-1:0]  in_position_ref,
  input  logic [REF_W-1:0]  in_texcoord_ref,
  input  logic [REF_W-1:0]  in_normal_ref,
  output logic              push_valid,
  input  logic              push_ready,
  output item_t             push_item
);

  logic             valid_r;
  item_t            item_r;
  item_t            item_nxt;
  logic [POS_W-1:0] pos_zb;
  logic             in_take;

  assign in_ready   = !valid_r || push_ready;
  assign in_take    = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    pos_zb       = (in_position_ref != '0) ? in_position_ref - 1'b1 : '0;
    item_nxt.pos = pos_zb;
    item_nxt.tex = (in_texcoord_ref != '0) ? in_texcoord_ref - 1'b1 : '0;
    item_nxt.nrm = (in_normal_ref != '0) ? in_normal_ref - 1'b1 : '0;
    if (in_operation == OP_RESTART) begin
      item_nxt.kind = KIND_RESTART;
    end else if (32'(pos_zb) >= 32'(POSITION_SLOTS)) begin
      item_nxt.kind = KIND_RANGE;
    end else begin
      item_nxt.kind = KIND_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_take) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== hw/rtl/mcid_queue.sv =====
// mcid_queue: two-entry request queue between front and back.
// Depends on mcid_pkg.
module mcid_queue import mcid_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t      entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/mcid_back.sv =====
// mcid_back: pair list memories, lookup / append sequencer, clearing sweep
// and result register. Depends on mcid_pkg.
module mcid_back import mcid_pkg::*; #(
  parameter int POSITION_SLOTS     = 4096,
  parameter int PAIRS_PER_POSITION = 10
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  output logic  q_ready,
  input  item_t q_item,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int AW    = $clog2(POSITION_SLOTS);
  localparam int CNT_W = $clog2(PAIRS_PER_POSITION + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE
  } state_t;

  typedef pair_t [PAIRS_PER_POSITION-1:0] row_t;

  // memories: per-position pair count and per-position row of pairs
  logic [CNT_W-1:0] cnt_mem [POSITION_SLOTS];
  row_t             row_mem [POSITION_SLOTS];

  state_t             state_r;
  logic [AW-1:0]      clr_addr_r;
  logic [INDEX_W-1:0] next_index_r;
  item_t              item_r;
  logic               hit_r;
  logic [INDEX_W-1:0] hit_idx_r;
  logic               out_valid_r;
  res_t               out_res_r;
  logic [CNT_W-1:0]   cnt_rd_r;
  row_t               row_rd_r;

  logic               out_free;
  logic               take;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      item_addr;
  logic               full;
  logic               append;
  logic               cnt_we;
  logic [AW-1:0]      cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  row_t               row_wdata;
  logic               hit_any;
  logic [INDEX_W-1:0] hit_idx;
  pair_t              new_pair;
  logic               res_load;
  res_t               range_res;
  res_t               decide_res;

  function automatic logic [AW-1:0] to_addr(logic [POS_W-1:0] pos);
    logic [31:0] ext;
    ext = 32'(pos);
    return ext[AW-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign q_ready   = (state_r == ST_IDLE) && out_free;
  assign take      = q_valid && q_ready;
  assign rd_en     = take && (q_item.kind == KIND_LOOKUP);
  assign rd_addr   = to_addr(q_item.pos);
  assign item_addr = to_addr(item_r.pos);
  assign full      = (cnt_rd_r == CNT_W'(PAIRS_PER_POSITION));
  assign append    = (state_r == ST_DECIDE) && !hit_r && !full;
  assign res_load  = (take && (q_item.kind != KIND_LOOKUP)) || (state_r == ST_DECIDE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // pair match over the valid part of the row, pairs in a list are unique
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < PAIRS_PER_POSITION; k++) begin
      if ((k < int'(cnt_rd_r)) && (row_rd_r[k].normal == item_r.nrm) &&
          (row_rd_r[k].texcoord == item_r.tex)) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | row_rd_r[k].index;
      end
    end
  end

  always_comb begin
    new_pair.normal   = item_r.nrm;
    new_pair.texcoord = item_r.tex;
    new_pair.index    = next_index_r;
    for (int k = 0; k < PAIRS_PER_POSITION; k++) begin
      row_wdata[k] = (k == int'(cnt_rd_r)) ? new_pair : row_rd_r[k];
    end
  end

  // result words for an out-of-range request and for the lookup decision
  always_comb begin
    range_res        = '0;
    range_res.status = STATUS_RANGE;
    decide_res       = '0;
    if (hit_r) begin
      decide_res.assigned_index = hit_idx_r;
    end else if (full) begin
      decide_res.status = STATUS_FULL;
    end else begin
      decide_res.assigned_index = next_index_r;
      decide_res.is_new         = 1'b1;
      decide_res.fetch_position = item_r.pos[11:0];
      decide_res.fetch_normal   = item_r.nrm;
      decide_res.fetch_texcoord = item_r.tex;
      decide_res.record_words   = record_len(cfg.attribute_mode, cfg.stride_bytes);
      decide_res.status         = STATUS_OK;
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_r;
      cnt_wdata = '0;
    end else begin
      cnt_we    = append;
      cnt_waddr = item_addr;
      cnt_wdata = cnt_rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (rd_en) begin
      cnt_rd_r <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      row_mem[item_addr] <= row_wdata;
    end
    if (rd_en) begin
      row_rd_r <= row_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      next_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= res_load || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (32'(clr_addr_r) == 32'(POSITION_SLOTS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            item_r <= q_item;
            unique case (q_item.kind)
              KIND_RESTART: begin
                out_res_r    <= '0;
                next_index_r <= cfg.index_offset;
                clr_addr_r   <= '0;
                state_r      <= ST_CLEAR;
              end
              KIND_RANGE: begin
                out_res_r <= range_res;
              end
              default: begin
                state_r <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: begin
          hit_r     <= hit_any;
          hit_idx_r <= hit_idx;
          state_r   <= ST_DECIDE;
        end
        ST_DECIDE: begin
          out_res_r <= decide_res;
          state_r   <= ST_IDLE;
          if (!hit_r && !full) begin
            next_index_r <= next_index_r + 1'b1;
          end
        end
      endcase
    end
  end

endmodule
